[src/bsc_pkg.sv]
package bsc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        t_reg_ac1_ac2 = 3'd0,
        t_reg_ac3_ac4 = 3'd1,
        t_reg_ac5_ac6 = 3'd2,
        t_reg_b1_b2   = 3'd3,
        t_reg_mc_md   = 3'd4,
        t_reg_oss     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        t_div_idle,
        t_div_run,
        t_div_done
    } t_div_state;

    // divider request/response between sequencer and divider
    typedef struct packed {
        logic        start;
        logic        sgn;      // signed (truncating) or unsigned divide
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    typedef enum logic [5:0] {
        t_s_idle,
        t_s_t0, t_s_t1, t_s_t2, t_s_t3, t_s_t4,
        t_s_p0, t_s_p1, t_s_p2, t_s_p3, t_s_p4, t_s_p5, t_s_p6, t_s_p7,
        t_s_p8, t_s_p9, t_s_p10, t_s_p11, t_s_p12, t_s_p13, t_s_p14,
        t_s_p15, t_s_p16, t_s_p17, t_s_p18, t_s_p19, t_s_p20,
        t_s_out
    } t_state;

endpackage

[src/barometric_sensor_compensation_unit.sv]
// Channel   Dir  Handshake             Payload
// input     in   i_valid / o_stall     i_op, i_raw_reading
// result    out  o_valid / i_stall     o_kind, o_value, o_div_error
// config    in   i_cfg_we              i_cfg_idx, i_cfg_data
//
// One item at a time; the time per item is set by the shared 32x32 multiplier
// steps and the serial divider. A zero divisor ends a temperature or pressure
// item before its divide. A stalled result holds the unit in its output state.
// Synchronous active-low reset clears the sequencer, the result valid, B5 and the config registers.
// o_stall stays high from acceptance until the result transfers.
module barometric_sensor_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [18:0] i_raw_reading,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic signed [31:0] o_value,
    output logic        o_div_error,
    input  logic        i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [1:0]  r_oss;
    logic signed [31:0] r_b5;
    bsc_pkg::t_state r_state, n_state;
    logic        r_op;
    logic [18:0] r_raw;
    logic signed [31:0] r_a, r_b, r_c, r_d, r_p;  // scratch terms
    logic signed [31:0] r_res;
    logic        r_err;
    bsc_pkg::t_div_req w_req;
    bsc_pkg::t_div_rsp w_rsp;

    // shared multiplier operands
    logic signed [31:0] w_ma, w_mb, w_prod;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0; r_oss <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsc_pkg::t_reg_ac1_ac2: r_c0 <= i_cfg_data;
                bsc_pkg::t_reg_ac3_ac4: r_c1 <= i_cfg_data;
                bsc_pkg::t_reg_ac5_ac6: r_c2 <= i_cfg_data;
                bsc_pkg::t_reg_b1_b2:   r_c3 <= i_cfg_data;
                bsc_pkg::t_reg_mc_md:   r_c4 <= i_cfg_data;
                bsc_pkg::t_reg_oss:     r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [31:0] w_ac4, w_ac5, w_ac6;
    assign w_ac1 = {{16{r_c0[31]}}, r_c0[31:16]};
    assign w_ac2 = {{16{r_c0[15]}}, r_c0[15:0]};
    assign w_ac3 = {{16{r_c1[31]}}, r_c1[31:16]};
    assign w_ac4 = {16'd0, r_c1[15:0]};
    assign w_ac5 = {16'd0, r_c2[31:16]};
    assign w_ac6 = {16'd0, r_c2[15:0]};
    assign w_b1  = {{16{r_c3[31]}}, r_c3[31:16]};
    assign w_b2  = {{16{r_c3[15]}}, r_c3[15:0]};
    assign w_mc  = {{16{r_c4[31]}}, r_c4[31:16]};
    assign w_md  = {{16{r_c4[15]}}, r_c4[15:0]};

    // truncating signed divide by 2^k
    function automatic logic signed [31:0] sdiv(input logic signed [31:0] v,
                                                input logic [4:0] k);
        logic [31:0] bias;
        bias = (32'd1 << k) - 32'd1;
        sdiv = v[31] ? ((v + $signed(bias)) >>> k) : (v >>> k);
    endfunction

    bsc_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // operand select for the multiplier
    always_comb begin
        w_ma = r_a;
        w_mb = r_b;
        unique case (r_state)
            bsc_pkg::t_s_t0:  begin w_ma = $signed({16'd0, r_raw[15:0]}) - $signed(w_ac6);
                                    w_mb = $signed(w_ac5); end
            bsc_pkg::t_s_p1:  begin w_ma = r_a; w_mb = r_a; end         // b6*b6
            bsc_pkg::t_s_p2:  begin w_ma = w_b2; w_mb = r_b; end        // b2*sq
            bsc_pkg::t_s_p3:  begin w_ma = w_ac2; w_mb = r_a; end       // ac2*b6
            bsc_pkg::t_s_p5:  begin w_ma = w_ac3; w_mb = r_a; end       // ac3*b6
            bsc_pkg::t_s_p6:  begin w_ma = w_b1; w_mb = r_b; end        // b1*sq
            bsc_pkg::t_s_p8:  begin w_ma = $signed(w_ac4); w_mb = r_c + 32'sd32768; end
            bsc_pkg::t_s_p9:  begin w_ma = $signed({13'd0, r_raw}) - r_d;
                                    w_mb = $signed(32'd50000 >> r_oss); end
            bsc_pkg::t_s_p14: begin w_ma = sdiv(r_p, 5'd8); w_mb = sdiv(r_p, 5'd8); end
            bsc_pkg::t_s_p15: begin w_ma = r_a; w_mb = 32'sd3038; end
            bsc_pkg::t_s_p16: begin w_ma = -32'sd7357; w_mb = r_p; end
            default: ;
        endcase
    end
    assign w_prod = 32'(w_ma * w_mb);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsc_pkg::t_s_idle: if (i_valid) n_state = i_op ? bsc_pkg::t_s_p0 : bsc_pkg::t_s_t0;
            bsc_pkg::t_s_t0:   n_state = bsc_pkg::t_s_t1;
            bsc_pkg::t_s_t1:   n_state = (r_a + w_md == 32'sd0) ? bsc_pkg::t_s_out
                                                                 : bsc_pkg::t_s_t2;
            bsc_pkg::t_s_t2:   n_state = bsc_pkg::t_s_t3;
            bsc_pkg::t_s_t3:   if (w_rsp.done) n_state = bsc_pkg::t_s_t4;
            bsc_pkg::t_s_t4:   n_state = bsc_pkg::t_s_out;
            bsc_pkg::t_s_p0:   n_state = bsc_pkg::t_s_p1;
            bsc_pkg::t_s_p1:   n_state = bsc_pkg::t_s_p2;
            bsc_pkg::t_s_p2:   n_state = bsc_pkg::t_s_p3;
            bsc_pkg::t_s_p3:   n_state = bsc_pkg::t_s_p4;
            bsc_pkg::t_s_p4:   n_state = bsc_pkg::t_s_p5;
            bsc_pkg::t_s_p5:   n_state = bsc_pkg::t_s_p6;
            bsc_pkg::t_s_p6:   n_state = bsc_pkg::t_s_p7;
            bsc_pkg::t_s_p7:   n_state = bsc_pkg::t_s_p8;
            bsc_pkg::t_s_p8:   n_state = bsc_pkg::t_s_p9;
            bsc_pkg::t_s_p9:   n_state = (r_c == 32'sd0) ? bsc_pkg::t_s_out : bsc_pkg::t_s_p10;
            bsc_pkg::t_s_p10:  n_state = bsc_pkg::t_s_p11;
            bsc_pkg::t_s_p11:  if (w_rsp.done) n_state = bsc_pkg::t_s_p12;
            bsc_pkg::t_s_p12:  n_state = bsc_pkg::t_s_p14;
            bsc_pkg::t_s_p14:  n_state = bsc_pkg::t_s_p15;
            bsc_pkg::t_s_p15:  n_state = bsc_pkg::t_s_p16;
            bsc_pkg::t_s_p16:  n_state = bsc_pkg::t_s_p17;
            bsc_pkg::t_s_p17:  n_state = bsc_pkg::t_s_out;
            bsc_pkg::t_s_out:  if (!i_stall) n_state = bsc_pkg::t_s_idle;
            default:           n_state = bsc_pkg::t_s_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bsc_pkg::t_s_idle;
        else          r_state <= n_state;
    end

    // divider request
    always_comb begin
        w_req.start = 1'b0;
        w_req.sgn   = 1'b1;
        w_req.num   = 32'(w_mc * 32'sd2048);
        w_req.den   = r_b;
        if (r_state == bsc_pkg::t_s_t2) w_req.start = 1'b1;
        if (r_state == bsc_pkg::t_s_p10) begin
            w_req.start = 1'b1;
            w_req.sgn   = 1'b0;
            w_req.num   = r_d[31] ? r_d : (r_d << 1);
            w_req.den   = r_c;
        end
    end

    // datapath; r_d holds b3 then b7, r_c holds x3 then b4
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bsc_pkg::t_s_idle: begin
                r_op <= i_op; r_raw <= i_raw_reading; r_err <= 1'b0;
            end
            bsc_pkg::t_s_t0: r_a <= sdiv(w_prod, 5'd15);           // x1
            bsc_pkg::t_s_t1: begin
                r_b <= r_a + w_md;
            end
            bsc_pkg::t_s_t2: ;
            bsc_pkg::t_s_t3: if (w_rsp.done) r_c <= w_rsp.quo;     // x2
            bsc_pkg::t_s_t4: r_res <= sdiv(r_a + r_c + 32'sd8, 5'd4);
            bsc_pkg::t_s_p0: r_a <= r_b5 - 32'sd4000;             // b6
            bsc_pkg::t_s_p1: r_b <= sdiv(w_prod, 5'd12);           // sq
            bsc_pkg::t_s_p2: r_c <= sdiv(w_prod, 5'd11);           // x1
            bsc_pkg::t_s_p3: r_c <= r_c + sdiv(w_prod, 5'd11);     // x3
            bsc_pkg::t_s_p4: r_d <= sdiv(32'((((w_ac1 <<< 2) + r_c) <<< r_oss) + 32'sd2),
                                     5'd2);                          // b3
            bsc_pkg::t_s_p5: r_c <= sdiv(w_prod, 5'd13);
            bsc_pkg::t_s_p6: r_c <= r_c + sdiv(w_prod, 5'd16);
            bsc_pkg::t_s_p7: r_c <= sdiv(r_c + 32'sd2, 5'd2);      // x3
            bsc_pkg::t_s_p8: r_c <= $signed(32'($unsigned(w_prod)) >> 15); // b4
            bsc_pkg::t_s_p9: r_d <= w_prod;                          // b7
            bsc_pkg::t_s_p11: if (w_rsp.done) r_p <= r_d[31] ? (w_rsp.quo << 1) : w_rsp.quo;
            bsc_pkg::t_s_p14: r_a <= w_prod;
            bsc_pkg::t_s_p15: r_a <= sdiv(w_prod, 5'd16);
            bsc_pkg::t_s_p16: r_b <= sdiv(w_prod, 5'd16);
            bsc_pkg::t_s_p17: r_res <= r_p + sdiv(r_a + r_b + 32'sd3791, 5'd4);
            default: ;
        endcase
        if ((r_state == bsc_pkg::t_s_t1 && r_a + w_md == 32'sd0) ||
            (r_state == bsc_pkg::t_s_p9 && r_c == 32'sd0)) begin
            r_err <= 1'b1;
            r_res <= '0;
        end
    end

    // kept B5 term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b5 <= '0;
        else if (r_state == bsc_pkg::t_s_t4) r_b5 <= r_a + r_c;
    end

    // outputs
    always_comb begin
        o_stall     = (r_state != bsc_pkg::t_s_idle);
        o_valid     = (r_state == bsc_pkg::t_s_out);
        o_kind      = r_op;
        o_value     = r_res;
        o_div_error = r_err;
    end

endmodule

[src/bsc_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module bsc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsc_pkg::t_div_req i_req,
    output bsc_pkg::t_div_rsp o_rsp
);

    bsc_pkg::t_div_state r_state, n_state;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_den, r_num;
    logic        r_neg;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsc_pkg::t_div_idle: if (i_req.start) n_state = bsc_pkg::t_div_run;
            bsc_pkg::t_div_run:  if (r_cnt == 5'd0) n_state = bsc_pkg::t_div_done;
            bsc_pkg::t_div_done: n_state = bsc_pkg::t_div_idle;
            default:             n_state = bsc_pkg::t_div_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bsc_pkg::t_div_idle;
        else          r_state <= n_state;
    end

    assign w_rem_sh = {r_rem[30:0], r_num[31]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_den};

    // datapath: magnitudes in, sign fixed at the end
    always_ff @(posedge i_clk) begin
        if (r_state == bsc_pkg::t_div_idle && i_req.start) begin
            r_num <= (i_req.sgn && i_req.num[31]) ? -i_req.num : i_req.num;
            r_den <= (i_req.sgn && i_req.den[31]) ? -i_req.den : i_req.den;
            r_neg <= i_req.sgn && (i_req.num[31] ^ i_req.den[31]);
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= 5'd31;
        end else if (r_state == bsc_pkg::t_div_run) begin
            r_num <= {r_num[30:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = (r_state == bsc_pkg::t_div_done);
    assign o_rsp.quo  = r_neg ? -r_quo : r_quo;

endmodule
